// ===== hw/rtl/lcmt_pkg.sv =====
package lcmt_pkg;

  // query point width; the tree spans 2**XW leaves
  localparam int unsigned XW = 20;
  localparam int unsigned Domain = 1 << XW;
  localparam int unsigned NodeW = XW + 1;
  localparam int unsigned Depth = 1 << NodeW;
  localparam int unsigned CoefW = 32;
  localparam int unsigned LineW = 2 * CoefW;
  localparam int unsigned ValW = 64;
  localparam int unsigned ProdW = CoefW + XW + 1;

  localparam logic signed [CoefW-1:0] SentinelVal = 32'sd1073741823;
  localparam logic signed [ValW-1:0] StartMin = 64'sd1152921502459363329;
  localparam logic [XW-1:0] DomainMax = XW'(Domain - 1);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StInsMul,
    StInsCmp,
    StQry,
    StDrain
  } state_e;

  typedef struct packed {
    logic             we;
    logic [NodeW-1:0] waddr;
    logic [LineW-1:0] wdata;
    logic [NodeW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hw/rtl/lichao_min_line_tree.sv =====
// channel  | ports                                              | handshake
// ---------+----------------------------------------------------+----------------------------
// command  | line_intercept_i, line_slope_i, query_point_i      | start_i && !busy_o
// result   | min_value_o                                        | done_o, one cycle, no stall
//
// an item walks the insert path through StInsMul then StInsCmp at each tree level (read, evaluate, compare/write),
// L levels with L from 1 to 21, then reads the 21 nodes of the query path one per cycle;
// done_o rises once the query path values have drained through the evaluator.
// after reset the node memory is swept to the sentinel line, all 2097152 nodes, with busy_o high.
// the result stays on min_value_o until the next start is taken; done_o cannot be stalled by the receiver.
module lichao_min_line_tree (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [lcmt_pkg::CoefW-1:0]    line_intercept_i,
  input  logic signed [lcmt_pkg::CoefW-1:0]    line_slope_i,
  input  logic        [lcmt_pkg::XW-1:0]       query_point_i,
  output logic signed [lcmt_pkg::ValW-1:0]     min_value_o,
  output logic                                 done_o
);

  lcmt_pkg::mem_req_t              mem_req;
  logic [lcmt_pkg::LineW-1:0]      mem_rdata;

  lcmt_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .line_intercept_i (line_intercept_i),
    .line_slope_i     (line_slope_i),
    .query_point_i    (query_point_i),
    .min_value_o      (min_value_o),
    .done_o           (done_o),
    .mem_req_o        (mem_req),
    .mem_rdata_i      (mem_rdata)
  );

  lcmt_ram #(
    .Width (lcmt_pkg::LineW),
    .Depth (lcmt_pkg::Depth)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== hw/rtl/lcmt_ram.sv =====
module lcmt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lcmt_eval.sv =====
module lcmt_eval (
  input  logic                                  clk_i,
  input  logic signed [lcmt_pkg::CoefW-1:0]     icpt_i,
  input  logic signed [lcmt_pkg::CoefW-1:0]     slope_i,
  input  logic        [lcmt_pkg::XW-1:0]        x_i,
  output logic signed [lcmt_pkg::ValW-1:0]      value_o
);

  logic signed [lcmt_pkg::CoefW-1:0] icpt_q;
  logic signed [lcmt_pkg::ProdW-1:0] prod_q;
  logic signed [lcmt_pkg::ProdW-1:0] prod_d;

  // x is unsigned, so give it a zero sign bit before the signed multiply
  assign prod_d = lcmt_pkg::ProdW'(slope_i * $signed({1'b0, x_i}));

  always_ff @(posedge clk_i) begin
    icpt_q <= icpt_i;
    prod_q <= prod_d;
  end

  assign value_o = lcmt_pkg::ValW'(icpt_q) + lcmt_pkg::ValW'(prod_q);

endmodule

// ===== hw/rtl/lcmt_ctrl.sv =====
module lcmt_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [lcmt_pkg::CoefW-1:0]    line_intercept_i,
  input  logic signed [lcmt_pkg::CoefW-1:0]    line_slope_i,
  input  logic        [lcmt_pkg::XW-1:0]       query_point_i,
  output logic signed [lcmt_pkg::ValW-1:0]     min_value_o,
  output logic                                 done_o,
  output lcmt_pkg::mem_req_t                   mem_req_o,
  input  logic        [lcmt_pkg::LineW-1:0]    mem_rdata_i
);

  localparam int unsigned XW = lcmt_pkg::XW;
  localparam int unsigned NodeW = lcmt_pkg::NodeW;
  localparam int unsigned CoefW = lcmt_pkg::CoefW;

  lcmt_pkg::state_e state_q, state_d;

  logic [NodeW-1:0] clr_q;
  logic             v1_q, v2_q, done_q;

  logic signed [CoefW-1:0] cur_icpt_q, cur_slope_q;
  logic signed [CoefW-1:0] old_icpt_q, old_slope_q;
  logic [NodeW-1:0]        node_q, qnode_q;
  logic [XW-1:0]           lo_q, hi_q, mid_q, x_q;
  logic signed [lcmt_pkg::ValW-1:0] best_q;

  logic signed [CoefW-1:0] rd_icpt, rd_slope;
  logic signed [CoefW-1:0] ea_icpt, ea_slope;
  logic [XW-1:0]           ea_x;
  logic signed [lcmt_pkg::ValW-1:0] val_a, val_b;

  logic                    swap, stop, go_left;
  logic signed [CoefW-1:0] keep_slope, carry_icpt, carry_slope;
  logic [NodeW-1:0]        node_nxt;
  logic [XW:0]             sum_l, sum_r;

  assign rd_icpt  = mem_rdata_i[lcmt_pkg::LineW-1:CoefW];
  assign rd_slope = mem_rdata_i[CoefW-1:0];

  // eval a: carried line at mid during insert, stored node at x during query
  lcmt_eval u_eval_a (
    .clk_i   (clk_i),
    .icpt_i  (ea_icpt),
    .slope_i (ea_slope),
    .x_i     (ea_x),
    .value_o (val_a)
  );

  // eval b: stored node line at mid
  lcmt_eval u_eval_b (
    .clk_i   (clk_i),
    .icpt_i  (rd_icpt),
    .slope_i (rd_slope),
    .x_i     (mid_q),
    .value_o (val_b)
  );

  // insert decision for the node in hand
  always_comb begin
    swap        = val_a < val_b;
    keep_slope  = swap ? cur_slope_q : old_slope_q;
    carry_icpt  = swap ? old_icpt_q : cur_icpt_q;
    carry_slope = swap ? old_slope_q : cur_slope_q;
    stop        = node_q[NodeW-1] || (carry_slope == keep_slope);
    go_left     = carry_slope > keep_slope;
    node_nxt    = {node_q[NodeW-2:0], ~go_left};
    sum_l       = {1'b0, lo_q} + {1'b0, mid_q};
    sum_r       = {1'b0, mid_q} + {1'b0, hi_q} + (XW+1)'(1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcmt_pkg::StClear: begin
        if (clr_q == '1) state_d = lcmt_pkg::StIdle;
      end
      lcmt_pkg::StIdle: begin
        if (start_i) state_d = lcmt_pkg::StInsMul;
      end
      lcmt_pkg::StInsMul: state_d = lcmt_pkg::StInsCmp;
      lcmt_pkg::StInsCmp: begin
        state_d = stop ? lcmt_pkg::StQry : lcmt_pkg::StInsMul;
      end
      lcmt_pkg::StQry: begin
        if (qnode_q == NodeW'(1)) state_d = lcmt_pkg::StDrain;
      end
      lcmt_pkg::StDrain: begin
        if (!v1_q && !v2_q) state_d = lcmt_pkg::StIdle;
      end
      default: state_d = lcmt_pkg::StIdle;
    endcase
  end

  // outputs: memory port, evaluator inputs and busy_o
  always_comb begin
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = node_q;
    mem_req_o.wdata = {cur_icpt_q, cur_slope_q};
    mem_req_o.raddr = NodeW'(1);
    ea_icpt  = rd_icpt;
    ea_slope = rd_slope;
    ea_x     = x_q;
    busy_o   = 1'b1;
    unique case (state_q)
      lcmt_pkg::StClear: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        mem_req_o.wdata = {lcmt_pkg::SentinelVal, lcmt_pkg::SentinelVal};
      end
      lcmt_pkg::StIdle: begin
        busy_o = 1'b0;
      end
      lcmt_pkg::StInsMul: begin
        ea_icpt  = cur_icpt_q;
        ea_slope = cur_slope_q;
        ea_x     = mid_q;
      end
      lcmt_pkg::StInsCmp: begin
        mem_req_o.we    = swap;
        mem_req_o.raddr = node_nxt;
      end
      lcmt_pkg::StQry: begin
        mem_req_o.raddr = qnode_q;
      end
      lcmt_pkg::StDrain: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcmt_pkg::StClear;
      clr_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lcmt_pkg::StClear) clr_q <= clr_q + NodeW'(1);
      v1_q   <= (state_q == lcmt_pkg::StQry);
      v2_q   <= v1_q;
      done_q <= (state_q == lcmt_pkg::StDrain) && !v1_q && !v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lcmt_pkg::StIdle: begin
        if (start_i) begin
          cur_icpt_q  <= line_intercept_i;
          cur_slope_q <= line_slope_i;
          node_q      <= NodeW'(1);
          lo_q        <= '0;
          hi_q        <= '1;
          mid_q       <= {1'b0, {(XW-1){1'b1}}};
          x_q         <= (query_point_i > lcmt_pkg::DomainMax) ? lcmt_pkg::DomainMax
                                                                : query_point_i;
          best_q      <= lcmt_pkg::StartMin;
        end
      end
      lcmt_pkg::StInsMul: begin
        old_icpt_q  <= rd_icpt;
        old_slope_q <= rd_slope;
      end
      lcmt_pkg::StInsCmp: begin
        cur_icpt_q  <= carry_icpt;
        cur_slope_q <= carry_slope;
        node_q      <= node_nxt;
        qnode_q     <= {1'b1, x_q};
        if (go_left) begin
          hi_q  <= mid_q;
          mid_q <= sum_l[XW:1];
        end else begin
          lo_q  <= mid_q + XW'(1);
          mid_q <= sum_r[XW:1];
        end
      end
      lcmt_pkg::StQry: begin
        qnode_q <= qnode_q >> 1;
      end
      default: begin
      end
    endcase
    // path values arrive through the RAM read register and the evaluator register, tracked by v1_q and v2_q
    if (v2_q && (val_a < best_q)) best_q <= val_a;
  end

  assign min_value_o = best_q;
  assign done_o      = done_q;

endmodule
